// File: design/pmj_pkg.sv
// ----------------------------------------------------------------------------
// pmj_pkg
// Shared types and constants for the timer jiffy accounting block.
// ----------------------------------------------------------------------------
package pmj_pkg;

    localparam logic [21:0] PM_FREQ   = 22'd3579545;
    // floor(2^44 / PM_FREQ), reciprocal for the jiffy quotient
    localparam logic [22:0] PM_RECIP  = 23'd4914643;
    localparam logic [8:0]  US_SCALE  = 9'd286;
    localparam logic [29:0] NS_PER_S  = 30'd1000000000;
    localparam logic [9:0]  NS_PER_US = 10'd1000;
    localparam int          DVW       = 22;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_RESUME = 2'd2;

    localparam logic CFG_HZ   = 1'b0;
    localparam logic CFG_JPRT = 1'b1;

    typedef enum logic [1:0] {
        DIV_JPRT,
        DIV_REM_HZ,
        DIV_NS_HZ
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     calc;
        logic     set_def;
        logic     resync;
        logic     qry_us;
        logic     qry_ns;
        logic     rec_mul;
        logic     rec_sub;
        logic     rec_fix;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     us_calc;
        logic     mul;
        logic     acc1;
        logic     acc2;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_query;
        logic is_resume;
        logic below;
        logic div_done;
        logic out_busy;
    } status_t;

    // counts * 286 wraps at 32 bits, then >> 10
    function automatic logic [21:0] to_us(input logic [31:0] counts);
        logic [31:0] p;
        p = counts * 32'(US_SCALE);
        return p[31:10];
    endfunction

endpackage

// File: design/pmj_div.sv
// ----------------------------------------------------------------------------
// pmj_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmj_div #(
    parameter int NW = 35
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NW-1:0]            dividend,
    input  logic [pmj_pkg::DVW-1:0]  divisor,
    output logic                     done,
    output logic [NW-1:0]            quotient,
    output logic [pmj_pkg::DVW-1:0]  remainder
);
    import pmj_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DVW-1:0]  rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DVW:0]    trial;
    logic [DVW:0]    diff;
    logic            ge;
    logic [DVW-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        ge       = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[DVW-1:0] : trial[DVW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNTW'(NW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNTW'(1);
            done_reg <= (cnt_reg == CNTW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: design/pmj_ctrl.sv
// ----------------------------------------------------------------------------
// pmj_ctrl
// Sequencer for capture, divisions, accumulation and result hand-off.
// ----------------------------------------------------------------------------
module pmj_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pmj_pkg::status_t sts,
    output pmj_pkg::cmd_t    cmd
);
    import pmj_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_QRY1,
        S_QRY2,
        S_REC1,
        S_REC2,
        S_REC3,
        S_DSTART,
        S_DWAIT,
        S_US,
        S_MUL,
        S_ACC1,
        S_ACC2,
        S_DONE
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        state_next  = state_reg;
        sel_next    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (sts.is_tick)
                begin
                    if (sts.below)
                    begin
                        cmd.set_def = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_REC1;
                    end
                end
                else if (sts.is_query)
                begin
                    state_next = S_QRY1;
                end
                else
                begin
                    cmd.resync = sts.is_resume;
                    state_next = S_DONE;
                end
            end
            S_QRY1:
            begin
                cmd.qry_us = 1'b1;
                state_next = S_QRY2;
            end
            S_QRY2:
            begin
                cmd.qry_ns = 1'b1;
                state_next = S_DONE;
            end
            S_REC1:
            begin
                cmd.rec_mul = 1'b1;
                state_next  = S_REC2;
            end
            S_REC2:
            begin
                cmd.rec_sub = 1'b1;
                state_next  = S_REC3;
            end
            S_REC3:
            begin
                cmd.rec_fix = 1'b1;
                sel_next    = DIV_JPRT;
                state_next  = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == DIV_NS_HZ)
                    begin
                        state_next = S_US;
                    end
                    else
                    begin
                        sel_next   = div_sel_t'(sel_reg + 2'd1);
                        state_next = S_DSTART;
                    end
                end
            end
            S_US:
            begin
                cmd.us_calc = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC1;
            end
            S_ACC1:
            begin
                cmd.acc1   = 1'b1;
                state_next = S_ACC2;
            end
            S_ACC2:
            begin
                cmd.acc2   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DIV_JPRT;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: design/pmj_dp.sv
// ----------------------------------------------------------------------------
// pmj_dp
// Datapath: config registers, timer state, shared divider and result regs.
// ----------------------------------------------------------------------------
module pmj_dp #(
    parameter int CW = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [9:0]       cfg_data,
    input  logic [1:0]       action,
    input  logic [23:0]      timer_sample,
    input  logic             out_ready,
    input  pmj_pkg::cmd_t    cmd,
    output pmj_pkg::status_t sts,
    output logic             out_valid,
    output logic             deferred,
    output logic [6:0]       jiffies_count,
    output logic signed [13:0] lost_ticks,
    output logic [32:0]      offset_ns,
    output logic [63:0]      monotonic_ns
);
    import pmj_pkg::*;

    localparam int NW = CW + 11;
    localparam int JW = CW - 10;
    localparam int RW = NW - 12;

    logic [9:0]  hz_reg;
    logic [6:0]  jprt_reg;
    logic [23:0] last_reg;
    logic [21:0] rem_reg;
    logic [19:0] off_us_reg;
    logic [19:0] prev_off_reg;
    logic [63:0] accum_reg;

    logic [1:0]    act_reg;
    logic [23:0]   smp_reg;
    logic [CW-1:0] elapsed_reg;
    logic [NW-1:0] delta_reg;
    logic [JW-1:0] qe_reg;
    logic [22:0]   rtry_reg;
    logic [JW-1:0] jta_reg;
    logic [JW-1:0] rt_reg;
    logic [6:0]    jmod_reg;
    logic [21:0]   qhz_reg;
    logic [29:0]   nsj_reg;
    logic [21:0]   usq_reg;
    logic [63:0]   prod1_reg;
    logic [63:0]   prod2_reg;

    logic        def_res;
    logic [6:0]  jc_res;
    logic [13:0] lost_res;
    logic [32:0] off_res;

    logic        out_valid_reg;
    logic        deferred_reg;
    logic [6:0]  jc_reg;
    logic [13:0] lost_reg;
    logic [32:0] offns_reg;
    logic [63:0] mono_reg;

    logic [9:0]     hz_eff;
    logic [6:0]     jprt_eff;
    logic [CW-1:0]  elapsed_next;
    logic [RW+22:0] rec_prod;
    logic [NW-1:0]  rtry_full;
    logic           rtry_ge;
    logic [NW-1:0]  div_dividend;
    logic [DVW-1:0] div_divisor;
    logic           div_done;
    logic [NW-1:0]  div_q;
    logic [DVW-1:0] div_r;
    logic [JW:0]    njif_sum;
    logic [JW:0]    njif;
    logic [19:0]    off_us_next;
    logic signed [20:0] off_diff;

    always_comb
    begin
        hz_eff       = (hz_reg == '0) ? 10'd1 : hz_reg;
        jprt_eff     = (jprt_reg == '0) ? 7'd1 : jprt_reg;
        elapsed_next = CW'(smp_reg) - CW'(last_reg);
        // reciprocal estimate is the true quotient or one below it
        rec_prod     = (RW+23)'(delta_reg[NW-1:12]) * (RW+23)'(PM_RECIP);
        rtry_full    = delta_reg - NW'((JW+22)'(qe_reg) * (JW+22)'(PM_FREQ));
        rtry_ge      = (rtry_reg >= 23'(PM_FREQ));
        njif_sum     = (JW+1)'(jprt_eff) + (JW+1)'(jmod_reg);
        njif         = (rt_reg == '0) ? (JW+1)'(jta_reg) : njif_sum;
        off_us_next  = 20'(to_us(32'(qhz_reg)));
        off_diff     = $signed({1'b0, off_us_reg}) - $signed({1'b0, prev_off_reg});
        unique case (cmd.div_sel)
            DIV_JPRT:
            begin
                div_dividend = NW'(jta_reg);
                div_divisor  = DVW'(jprt_eff);
            end
            DIV_REM_HZ:
            begin
                div_dividend = NW'(rem_reg);
                div_divisor  = DVW'(hz_eff);
            end
            default:
            begin
                div_dividend = NW'(NS_PER_S);
                div_divisor  = DVW'(hz_eff);
            end
        endcase
    end

    pmj_div #(
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // architectural state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg     <= 10'd1000;
            jprt_reg   <= 7'd1;
            last_reg   <= '0;
            rem_reg    <= '0;
            off_us_reg <= '0;
            accum_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HZ:   hz_reg   <= cfg_data;
                    CFG_JPRT: jprt_reg <= cfg_data[6:0];
                    default:  hz_reg   <= hz_reg;
                endcase
            end
            if (cmd.resync)
            begin
                last_reg <= smp_reg;
            end
            if (cmd.rec_fix)
            begin
                last_reg <= smp_reg;
                rem_reg  <= rtry_ge ? 22'(rtry_reg - 23'(PM_FREQ)) : rtry_reg[21:0];
            end
            if (cmd.us_calc)
            begin
                off_us_reg <= off_us_next;
            end
            if (cmd.acc1)
            begin
                accum_reg <= accum_reg + prod1_reg;
            end
            else if (cmd.acc2)
            begin
                accum_reg <= accum_reg + prod2_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            smp_reg <= timer_sample;
        end
        if (cmd.calc)
        begin
            elapsed_reg <= elapsed_next;
            def_res     <= 1'b0;
            jc_res      <= '0;
            lost_res    <= '1;
            off_res     <= '0;
        end
        if (cmd.calc)
        begin
            delta_reg <= NW'(elapsed_next) * NW'(hz_reg) + NW'(rem_reg);
        end
        if (cmd.set_def)
        begin
            def_res <= 1'b1;
        end
        if (cmd.qry_us)
        begin
            usq_reg <= to_us(32'(elapsed_reg));
        end
        if (cmd.qry_ns)
        begin
            off_res <= (33'(off_us_reg) + 33'(usq_reg)) * 33'(NS_PER_US);
        end
        if (cmd.rec_mul)
        begin
            qe_reg <= JW'(rec_prod[RW+22:32]);
        end
        if (cmd.rec_sub)
        begin
            rtry_reg <= 23'(rtry_full);
        end
        if (cmd.rec_fix)
        begin
            jta_reg <= rtry_ge ? qe_reg + JW'(1) : qe_reg;
        end
        if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                DIV_JPRT:
                begin
                    rt_reg   <= JW'(div_q);
                    jmod_reg <= 7'(div_r);
                end
                DIV_REM_HZ: qhz_reg <= 22'(div_q);
                default:    nsj_reg <= 30'(div_q);
            endcase
        end
        if (cmd.us_calc)
        begin
            prev_off_reg <= off_us_reg;
            jc_res       <= (njif > (JW+1)'(127)) ? 7'd127 : 7'(njif);
            lost_res     <= 14'(rt_reg - JW'(1));
        end
        if (cmd.mul)
        begin
            prod1_reg <= 64'((JW+30)'(jta_reg) * (JW+30)'(nsj_reg));
            prod2_reg <= 64'(off_diff) * 64'(NS_PER_US);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            deferred_reg <= def_res;
            jc_reg       <= jc_res;
            lost_reg     <= lost_res;
            offns_reg    <= off_res;
            mono_reg     <= accum_reg;
        end
    end

    always_comb
    begin
        sts.is_tick   = (act_reg == ACT_TICK);
        sts.is_query  = (act_reg == ACT_QUERY);
        sts.is_resume = (act_reg == ACT_RESUME);
        sts.below     = (delta_reg < NW'(PM_FREQ));
        sts.div_done  = div_done;
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign deferred      = deferred_reg;
    assign jiffies_count = jc_reg;
    assign lost_ticks    = $signed(lost_reg);
    assign offset_ns     = offns_reg;
    assign monotonic_ns  = mono_reg;

endmodule

// File: design/pm_timer_jiffy_accounting.sv
// ----------------------------------------------------------------------------
// pm_timer_jiffy_accounting
// Turns power management timer samples into jiffies and a nanosecond clock.
// ----------------------------------------------------------------------------
// one item at a time; a new transfer is taken only in the idle state
// tick: reciprocal steps, then three passes of the shared one-bit-per-cycle
//   divider, then accumulation; deferred tick, resume, unused code skip these
// query adds the qry1 and qry2 states; every result waits while output stalls
// next transfer is taken in the cycle after the result is loaded
// reset: hz 1000, jiffies per tick 1, all timer state and accumulator zero
module pm_timer_jiffy_accounting #(
    parameter int COUNTER_WIDTH = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [9:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [23:0]       timer_sample,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              deferred,
    output logic [6:0]        jiffies_count,
    output logic signed [13:0] lost_ticks,
    output logic [32:0]       offset_ns,
    output logic [63:0]       monotonic_ns
);
    import pmj_pkg::*;

    cmd_t    cmd;
    status_t sts;

    pmj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pmj_dp #(
        .CW (COUNTER_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .timer_sample  (timer_sample),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .deferred      (deferred),
        .jiffies_count (jiffies_count),
        .lost_ticks    (lost_ticks),
        .offset_ns     (offset_ns),
        .monotonic_ns  (monotonic_ns)
    );

endmodule

// File: design/pmj_checker.sv
// ----------------------------------------------------------------------------
// pmj_checker
// Port-level checks for the timer jiffy accounting block.
// ----------------------------------------------------------------------------
module pmj_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              deferred,
    input logic [6:0]        jiffies_count,
    input logic signed [13:0] lost_ticks,
    input logic [32:0]       offset_ns,
    input logic [63:0]       monotonic_ns
);

    // a stalled result holds its valid, deferred, offset and monotonic fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(monotonic_ns)
            && $stable(offset_ns) && $stable(deferred))
        else $error("result changed while stalled");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while busy");

    a_def_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deferred |-> jiffies_count == 7'd0
            && lost_ticks == -14'sd1 && offset_ns == 33'd0)
        else $error("deferred result carries tick values");

    a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && offset_ns != 33'd0 |-> !deferred && jiffies_count == 7'd0)
        else $error("query result carries tick values");

    a_tick_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lost_ticks != -14'sd1 |-> jiffies_count != 7'd0)
        else $error("accounted tick with zero length");

endmodule

bind pm_timer_jiffy_accounting pmj_checker u_pmj_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .deferred      (deferred),
    .jiffies_count (jiffies_count),
    .lost_ticks    (lost_ticks),
    .offset_ns     (offset_ns),
    .monotonic_ns  (monotonic_ns)
);

// File: dv/tb_pm_timer_jiffy_accounting.sv
// ----------------------------------------------------------------------------
// tb_pm_timer_jiffy_accounting
// Drives timer samples through tick, query, resume and unused actions under random
// flow control and compares every result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_pm_timer_jiffy_accounting;
    timeunit 1ns;
    timeprecision 1ps;

    import pmj_pkg::*;

    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [23:0] CNT_MASK   = 24'hFFFFFF;
    localparam int          TICK_DRAIN = 200;

    typedef struct packed {
        logic        deferred;
        logic [6:0]  jiffies_count;
        logic [13:0] lost_ticks;
        logic [32:0] offset_ns;
        logic [63:0] monotonic_ns;
    } acct_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [23:0] timer_sample;
    logic        out_valid;
    logic        out_ready;
    logic        deferred;
    logic [6:0]  jiffies_count;
    logic signed [13:0] lost_ticks;
    logic [32:0] offset_ns;
    logic [63:0] monotonic_ns;

    // predictor state
    logic [9:0]  m_hz;
    logic [6:0]  m_jprt;
    logic [23:0] m_last;
    logic [31:0] m_rem;
    logic [31:0] m_off_us;
    logic [63:0] m_mono;

    acct_result_t pending_results[$];
    int  errors;
    bit  burst_mode;
    bit  hold_rx;
    int  tx_gap_max;
    int  rx_phase;

    pm_timer_jiffy_accounting uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .timer_sample(timer_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .deferred(deferred), .jiffies_count(jiffies_count),
        .lost_ticks(lost_ticks), .offset_ns(offset_ns),
        .monotonic_ns(monotonic_ns)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] counts_to_us(input logic [31:0] counts);
        logic [31:0] p;
        p = counts * 32'd286;
        return {10'd0, p[31:10]};
    endfunction

    function automatic acct_result_t predict_accounting(input logic [1:0] act,
                                                       input logic [23:0] smp);
        acct_result_t r;
        logic [23:0] elapsed;
        logic [63:0] delta, jta, whole_ticks, njif, hz_eff, dv;
        logic [31:0] prev_off;
        elapsed = (smp - m_last) & CNT_MASK;
        r = '0;
        r.lost_ticks = 14'h3FFF;
        if (act == ACT_TICK)
        begin
            delta = 64'(elapsed) * 64'(m_hz) + 64'(m_rem);
            if (delta < 64'd3579545)
            begin
                r.deferred = 1'b1;
            end
            else
            begin
                hz_eff = (m_hz == 0) ? 64'd1 : 64'(m_hz);
                dv = (m_jprt == 0) ? 64'd1 : 64'(m_jprt);
                prev_off = m_off_us;
                jta = delta / 64'd3579545;
                whole_ticks = jta / dv;
                m_last = smp;
                m_rem = 32'(delta % 64'd3579545);
                m_off_us = counts_to_us(32'(64'(m_rem) / hz_eff));
                njif = (whole_ticks < 1) ? jta : dv + jta % dv;
                r.jiffies_count = (njif > 127) ? 7'd127 : njif[6:0];
                r.lost_ticks = 14'(whole_ticks - 64'd1);
                m_mono = m_mono + jta * (64'd1000000000 / hz_eff)
                    + (64'(m_off_us) - 64'(prev_off)) * 64'd1000;
            end
        end
        else if (act == ACT_QUERY)
        begin
            r.offset_ns = 33'((64'(m_off_us) + 64'(counts_to_us(32'(elapsed))))
                * 64'd1000);
        end
        else if (act == ACT_RESUME)
        begin
            m_last = smp;
        end
        r.monotonic_ns = m_mono;
        return r;
    endfunction

    task automatic send_sample(input logic [1:0] act, input logic [23:0] smp);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        timer_sample <= smp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_accounting(act, smp));
        if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TICK_DRAIN) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [9:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_HZ) m_hz = val;
        else m_jprt = val[6:0];
    endtask

    // sample offset giving roughly n jiffies at current hz
    function automatic logic [23:0] ahead_by(input int n);
        logic [63:0] c;
        c = (m_hz == 0) ? 64'd1000 : (64'd3579545 * 64'(n)) / 64'(m_hz) + 1;
        if (c > 64'hFFFFFF) c = 64'hFFFFFF;
        return m_last + c[23:0];
    endfunction

    always @(posedge clk)
    begin
        acct_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t unexpected result mono=%0d", $realtime, monotonic_ns);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (deferred !== exp_r.deferred || jiffies_count !== exp_r.jiffies_count
                    || lost_ticks !== exp_r.lost_ticks || offset_ns !== exp_r.offset_ns
                    || monotonic_ns !== exp_r.monotonic_ns)
                begin
                    $display("%t mismatch expected def=%0d jc=%0d lost=%0d off=%0d mono=%0d",
                        $realtime, exp_r.deferred, exp_r.jiffies_count,
                        $signed(exp_r.lost_ticks), exp_r.offset_ns, exp_r.monotonic_ns);
                    $display("%t          actual   def=%0d jc=%0d lost=%0d off=%0d mono=%0d",
                        $realtime, deferred, jiffies_count, lost_ticks,
                        offset_ns, monotonic_ns);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    always @(posedge clk)
    begin
        rx_phase <= (rx_phase == 22) ? 0 : rx_phase + 1;
        if (hold_rx)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (rx_phase < 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic test_directed();
        send_sample(ACT_TICK, 24'd0);
        send_sample(ACT_TICK, 24'd3579);
        send_sample(ACT_TICK, 24'd3580);
        send_sample(ACT_QUERY, 24'd3700);
        send_sample(ACT_QUERY, CNT_MASK);
        send_sample(ACT_UNUSED, 24'h123456);
        send_sample(ACT_RESUME, CNT_MASK);
        send_sample(ACT_TICK, 24'd5000);
        send_sample(ACT_TICK, CNT_MASK);
        send_sample(ACT_RESUME, 24'd0);
        send_sample(ACT_TICK, CNT_MASK);
        send_sample(ACT_QUERY, 24'h800000);
        wait_drained();
        write_cfg(CFG_HZ, 10'd0);
        send_sample(ACT_TICK, 24'h400000);
        send_sample(ACT_QUERY, 24'h400000);
        wait_drained();
        write_cfg(CFG_HZ, 10'd1023);
        write_cfg(CFG_JPRT, 10'd0);
        send_sample(ACT_TICK, 24'hAAAAAA);
        send_sample(ACT_TICK, 24'h555555);
        wait_drained();
        write_cfg(CFG_JPRT, 10'd127);
        send_sample(ACT_TICK, 24'h555555 + 24'd600000);
        send_sample(ACT_TICK, ahead_by(1000));
        wait_drained();
    endtask

    task automatic test_random_phase(input logic [9:0] hz_v, input logic [6:0] jp_v,
                                     input int count);
        int k;
        logic [1:0] act;
        logic [23:0] smp;
        write_cfg(CFG_HZ, hz_v);
        write_cfg(CFG_JPRT, {3'd0, jp_v});
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0: begin act = ACT_QUERY; smp = 24'($urandom); end
                1: begin act = ACT_RESUME; smp = 24'($urandom); end
                2: begin act = ACT_UNUSED; smp = 24'($urandom); end
                3: begin act = ACT_TICK; smp = 24'($urandom); end
                4: begin act = ACT_QUERY; smp = m_last + 24'($urandom_range(0, 20000)); end
                default:
                begin
                    act = ACT_TICK;
                    smp = ($urandom_range(0, 4) == 0)
                        ? m_last + 24'($urandom_range(0, 4000))
                        : ahead_by($urandom_range(1, 300));
                end
            endcase
            send_sample(act, smp);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            for (k = 0; k < 12; k++) send_sample(ACT_TICK, ahead_by(2));
        join
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        burst_mode = 0;
        hold_rx = 0;
        tx_gap_max = 6;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_TICK;
        timer_sample = '0;
        m_hz = 10'd1000;
        m_jprt = 7'd1;
        m_last = '0;
        m_rem = '0;
        m_off_us = '0;
        m_mono = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_random_phase(10'd1000, 7'd1, 100);
        test_random_phase(10'd1, 7'd64, 60);
        test_random_phase(10'd250, 7'd4, 80);
        test_backpressure();
        test_random_phase(10'd1023, 7'd127, 60);
        test_random_phase(10'd100, 7'd0, 60);
        test_random_phase(10'($urandom_range(1, 1023)), 7'($urandom_range(0, 127)), 60);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
